@@ rtl/nvc_pkg.sv @@
// Shared constants and types for the normalized vector correlation block.
// No dependencies; every other file imports this package.

package nvc_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int RAW_W      = 24;
  localparam int NORM_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int FRAC_BITS  = 15;
  localparam int MAX_LEN_DEF = 256;

  // largest square of one sample: (-2^(SAMPLE_W-1))^2
  localparam int SQ_MAX = 2 ** (2 * SAMPLE_W - 2);

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LONG = 2'd2;

  typedef struct packed {
    logic acc;        // add accepted pair into accumulators
    logic start;      // load energy product, init root and divider
    logic sqrt_step;  // one root bit
    logic div_step;   // one quotient bit
    logic load_out;   // capture result word and clear accumulators
  } nvc_cmd_t;

  typedef struct packed {
    logic skip;       // length overflow or zero energy: no root/divide
  } nvc_stat_t;

endpackage

@@ rtl/nvc_in_if.sv @@
// Input channel: one sample pair per word, with last marker.
// Depends on nvc_pkg.

interface nvc_in_if import nvc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_a;
  logic signed [SAMPLE_W-1:0] sample_b;
  logic                       last_pair;

  modport source (output valid, sample_a, sample_b, last_pair, input ready);
  modport sink   (input valid, sample_a, sample_b, last_pair, output ready);
endinterface

@@ rtl/nvc_out_if.sv @@
// Output channel: raw and normalized correlation with status.
// Depends on nvc_pkg.

interface nvc_out_if import nvc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [RAW_W-1:0]    raw_corr;
  logic signed [NORM_W-1:0]   norm_corr_q15;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, raw_corr, norm_corr_q15, status, input ready);
  modport sink   (input valid, raw_corr, norm_corr_q15, status, output ready);
endinterface

@@ rtl/normalized_vector_correlation.sv @@
// Top level of the normalized vector correlation block: sequencer plus datapath.
// Depends on nvc_pkg, nvc_in_if, nvc_out_if, nvc_ctrl, nvc_dp.
//
//  channel  dir  word                                   handshake
//  in_i     in   sample_a, sample_b, last_pair          valid/ready
//  out_o    out  raw_corr, norm_corr_q15, status        valid/ready
//
// Non-last pairs are accumulated without stalling. After the last pair, the
// block loads the energy product, runs the one-bit-per-cycle root unit, then
// the one-bit-per-cycle divider, and enters a hand-off state; it takes no new
// pair until that hand-off, where its result is registered.
// Overflowed or zero-energy vectors skip root and divide.
// The output register holds a result while new pairs are accepted; a
// stalled output only holds the block in its hand-off cycle.
// Reset is asynchronous, active low, and clears all accumulators.

module normalized_vector_correlation import nvc_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  nvc_in_if.sink    in_i,
  nvc_out_if.source out_o
);

  localparam int EN_W = $clog2(MAX_LEN * SQ_MAX + 1);

  nvc_cmd_t  cmd;
  nvc_stat_t stat;

  nvc_ctrl #(
    .SQRT_STEPS (EN_W),
    .DIV_STEPS  (EN_W + FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_pair),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  nvc_dp #(
    .MAX_LEN (MAX_LEN),
    .EN_W    (EN_W)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .sample_a_i      (in_i.sample_a),
    .sample_b_i      (in_i.sample_b),
    .raw_corr_o      (out_o.raw_corr),
    .norm_corr_q15_o (out_o.norm_corr_q15),
    .status_o        (out_o.status)
  );

endmodule

@@ rtl/nvc_ctrl.sv @@
// Sequencer: accumulate, then root and divide iterations, then result hand-off.
// Depends on nvc_pkg.

module nvc_ctrl import nvc_pkg::*; #(
  parameter int SQRT_STEPS = 23,
  parameter int DIV_STEPS  = 38
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  nvc_stat_t stat_i,
  output nvc_cmd_t  cmd_o
);

  localparam int CNT_W = $clog2(DIV_STEPS > SQRT_STEPS ? DIV_STEPS : SQRT_STEPS);

  localparam logic [2:0] S_ACC  = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_ACC: begin
        in_ready_o = 1'b1;
        cmd_o.acc  = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.start = 1'b1;
        cnt_d       = '0;
        state_d     = stat_i.skip ? S_DONE : S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        // output register free or draining this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/nvc_dp.sv @@
// Datapath: accumulators, energy product, bit-serial root and divider,
// result register. Depends on nvc_pkg.

module nvc_dp import nvc_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int EN_W    = 23
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nvc_cmd_t                   cmd_i,
  output nvc_stat_t                  stat_o,
  input  logic signed [SAMPLE_W-1:0] sample_a_i,
  input  logic signed [SAMPLE_W-1:0] sample_b_i,
  output logic signed [RAW_W-1:0]    raw_corr_o,
  output logic signed [NORM_W-1:0]   norm_corr_q15_o,
  output logic        [STATUS_W-1:0] status_o
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int DOT_W = EN_W + 1;
  localparam int PW    = 2 * EN_W;
  localparam int RW    = EN_W + 2;
  localparam int NW    = EN_W + FRAC_BITS;
  localparam int SQ_W  = 2 * SAMPLE_W;

  localparam logic [NW-1:0] POS_MAX = NW'(2 ** (NORM_W - 1) - 1);
  localparam logic [NW-1:0] NEG_MAX = NW'(2 ** (NORM_W - 1));

  // accumulators
  logic [CNT_W-1:0]        cnt_q;
  logic signed [DOT_W-1:0] dot_q;
  logic [EN_W-1:0]         ea_q, eb_q;
  logic                    ovf_q;

  logic signed [SQ_W-1:0] ab, aa, bb;
  logic                   ovf_now, zero_en;

  assign ab      = sample_a_i * sample_b_i;
  assign aa      = sample_a_i * sample_a_i;
  assign bb      = sample_b_i * sample_b_i;
  assign ovf_now = ovf_q || (cnt_q >= CNT_W'(MAX_LEN));
  assign zero_en = (ea_q == '0) || (eb_q == '0);
  assign stat_o.skip = ovf_q || zero_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      dot_q <= '0;
      ea_q  <= '0;
      eb_q  <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      cnt_q <= '0;
      dot_q <= '0;
      ea_q  <= '0;
      eb_q  <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.acc) begin
      if (ovf_now) begin
        ovf_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
        dot_q <= dot_q + DOT_W'(ab);
        ea_q  <= ea_q + EN_W'($unsigned(aa));
        eb_q  <= eb_q + EN_W'($unsigned(bb));
      end
    end
  end

  // magnitude and sign of the dot product
  logic            neg;
  logic [EN_W-1:0] mag;
  assign neg = dot_q[DOT_W-1];
  assign mag = neg ? EN_W'(-dot_q) : EN_W'(dot_q);

  // root: two radicand bits per step; divide: one dividend bit per step
  logic [PW-1:0]   prod_q;
  logic [RW-1:0]   rem_r_q;
  logic [EN_W-1:0] root_q;
  logic [EN_W:0]   rem_d_q;
  logic [NW-1:0]   dvd_q;   // dividend bits out the top, quotient bits in the bottom

  logic [RW-1:0]   r_sh, r_trial;
  logic            r_fit;
  logic [EN_W:0]   d_sh;
  logic            d_fit;

  assign r_sh    = {rem_r_q[RW-3:0], prod_q[PW-1 -: 2]};
  assign r_trial = {root_q, 2'b01};
  assign r_fit   = r_sh >= r_trial;
  assign d_sh    = {rem_d_q[EN_W-1:0], dvd_q[NW-1]};
  assign d_fit   = d_sh >= {1'b0, root_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      prod_q  <= ea_q * eb_q;
      rem_r_q <= '0;
      root_q  <= '0;
      rem_d_q <= '0;
      dvd_q   <= {mag, FRAC_BITS'(0)};
    end else if (cmd_i.sqrt_step) begin
      prod_q  <= {prod_q[PW-3:0], 2'b00};
      rem_r_q <= r_fit ? (r_sh - r_trial) : r_sh;
      root_q  <= {root_q[EN_W-2:0], r_fit};
    end else if (cmd_i.div_step) begin
      rem_d_q <= d_fit ? (d_sh - {1'b0, root_q}) : d_sh;
      dvd_q   <= {dvd_q[NW-2:0], d_fit};
    end
  end

  // clamp to Q1.15
  logic signed [NORM_W-1:0] norm;
  always_comb begin
    if (neg) begin
      norm = (dvd_q > NEG_MAX) ? NORM_W'(NEG_MAX) : NORM_W'(-dvd_q);
    end else begin
      norm = (dvd_q > POS_MAX) ? NORM_W'(POS_MAX) : NORM_W'(dvd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (ovf_q) begin
        raw_corr_o      <= '0;
        norm_corr_q15_o <= '0;
        status_o        <= ST_LONG;
      end else if (zero_en) begin
        raw_corr_o      <= RAW_W'(dot_q);
        norm_corr_q15_o <= '0;
        status_o        <= ST_ZERO;
      end else begin
        raw_corr_o      <= RAW_W'(dot_q);
        norm_corr_q15_o <= norm;
        status_o        <= ST_OK;
      end
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for normalized_vector_correlation: a directed table, then random vectors.
// Depends on nvc_pkg, nvc_in_if, nvc_out_if and the RTL top level.

module tb_top;
  import nvc_pkg::*;

  localparam int CORR_LEN_MAX = MAX_LEN_DEF;
  localparam int RAND_ITEMS   = 60;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_CYC   = 80;
  localparam int DIR_ROWS     = 20;
  localparam longint NORM_POS = 2 ** (NORM_W - 1) - 1;
  localparam longint NORM_NEG = 2 ** (NORM_W - 1);

  typedef struct packed {
    logic signed [RAW_W-1:0]  raw;
    logic signed [NORM_W-1:0] norm;
    logic [STATUS_W-1:0]      st;
  } corr_res_t;

  // one table row: reps pairs of (a, b); last and the typed result apply to the final pair
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic [9:0]                 reps;
    logic                       last;
    logic                       typed;
    corr_res_t                  want;
  } stim_row_t;

  typedef enum int {VEC_RANDOM, VEC_A_ZERO, VEC_B_ZERO, VEC_SAME, VEC_NEG, VEC_EXTREME} vec_kind_t;

  localparam corr_res_t NO_RES = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  nvc_in_if  in_if ();
  nvc_out_if out_if ();

  normalized_vector_correlation #(.MAX_LEN(CORR_LEN_MAX)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  corr_res_t corr_q[$];
  int        err_cnt = 0;
  int        cyc_cnt = 0;
  int        send_idle_pct;
  int        recv_stall_pct;

  // predictor state
  int unsigned     pairs_seen;
  longint          dot_acc;
  longint unsigned energy_a;
  longint unsigned energy_b;
  bit              too_long;

  stim_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{8'sd127,   8'sd127,   10'd1,   1'b1, 1'b1, '{24'sd16129,   16'sd32767, ST_OK}},
    '{-8'sd128,  8'sd127,   10'd1,   1'b1, 1'b1, '{-24'sd16256,  16'sh8000,  ST_OK}},
    '{-8'sd128,  -8'sd128,  10'd1,   1'b1, 1'b1, '{24'sd16384,   16'sd32767, ST_OK}},
    '{8'sd0,     8'sd5,     10'd1,   1'b1, 1'b1, '{24'sd0,       16'sd0,     ST_ZERO}},
    '{8'sd9,     8'sd0,     10'd1,   1'b1, 1'b1, '{24'sd0,       16'sd0,     ST_ZERO}},
    '{8'sd0,     8'sd0,     10'd1,   1'b1, 1'b1, '{24'sd0,       16'sd0,     ST_ZERO}},
    '{8'sd5,     8'sd0,     10'd1,   1'b0, 1'b0, NO_RES},
    '{8'sd0,     8'sd7,     10'd1,   1'b1, 1'b0, NO_RES},
    '{8'sd3,     -8'sd4,    10'd1,   1'b0, 1'b0, NO_RES},
    '{-8'sd1,    8'sd2,     10'd1,   1'b1, 1'b0, NO_RES},
    '{8'sd127,   -8'sd1,    10'd3,   1'b0, 1'b0, NO_RES},
    '{-8'sd128,  8'sd1,     10'd1,   1'b1, 1'b0, NO_RES},
    // full-length vector: largest raw sum, quotient of exactly one
    '{-8'sd128,  -8'sd128,  10'd256, 1'b1, 1'b1, '{24'sd4194304,  16'sd32767, ST_OK}},
    '{-8'sd128,  8'sd127,   10'd2,   1'b1, 1'b1, '{-24'sd32512,   16'sh8000,  ST_OK}},
    // two pairs past the limit, the last one arriving while overflowed
    '{8'sd1,     8'sd1,     10'd258, 1'b1, 1'b1, '{24'sd0,       16'sd0,     ST_LONG}},
    '{8'sd127,   8'sd127,   10'd3,   1'b0, 1'b0, NO_RES},
    '{-8'sd7,    8'sd3,     10'd1,   1'b1, 1'b0, NO_RES},
    '{8'sd2,     8'sd3,     10'd1,   1'b1, 1'b0, NO_RES},
    '{8'sd85,    -8'sd86,   10'd1,   1'b0, 1'b0, NO_RES},
    '{-8'sd86,   8'sd85,    10'd1,   1'b1, 1'b0, NO_RES}
  };

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void clear_sums();
    pairs_seen = 0;
    dot_acc    = 0;
    energy_a   = 0;
    energy_b   = 0;
    too_long   = 1'b0;
  endfunction

  // accumulate one pair; returns 1 with the correlation word when the pair closes a vector
  function automatic bit correlate_pair(input logic signed [SAMPLE_W-1:0] a,
                                        input logic signed [SAMPLE_W-1:0] b,
                                        input logic last, output corr_res_t res);
    longint          sa;
    longint          sb;
    longint unsigned root;
    longint unsigned mag;
    longint unsigned quo;
    sa  = longint'(a);
    sb  = longint'(b);
    res = '0;
    if (too_long || pairs_seen >= CORR_LEN_MAX) begin
      too_long = 1'b1;
    end else begin
      dot_acc    += sa * sb;
      energy_a   += sa * sa;
      energy_b   += sb * sb;
      pairs_seen++;
    end
    if (!last) return 1'b0;
    if (too_long) begin
      res.st = ST_LONG;
    end else begin
      res.raw = dot_acc[RAW_W-1:0];
      root = (energy_a != 0 && energy_b != 0) ? floor_root(energy_a * energy_b) : 0;
      if (root == 0) begin
        res.st = ST_ZERO;
      end else begin
        res.st = ST_OK;
        mag = (dot_acc < 0) ? -dot_acc : dot_acc;
        quo = (mag << FRAC_BITS) / root;
        if (dot_acc < 0)
          res.norm = NORM_W'((quo > NORM_NEG) ? -NORM_NEG : -longint'(quo));
        else
          res.norm = NORM_W'((quo > NORM_POS) ? NORM_POS : quo);
      end
    end
    clear_sums();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] a,
                           input logic signed [SAMPLE_W-1:0] b,
                           input logic last, input bit use_typed, input corr_res_t typed_res);
    corr_res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_a  <= a;
    in_if.sample_b  <= b;
    in_if.last_pair <= last;
    do @(posedge clk_i); while (!in_if.ready);
    if (correlate_pair(a, b, last, pred))
      corr_q.push_back(use_typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (corr_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_if.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin : result_check
    corr_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (corr_q.size() == 0) begin
        report_mismatch("unexpected word, raw_corr", out_if.raw_corr, 0);
      end else begin
        want = corr_q.pop_front();
        if (out_if.raw_corr !== want.raw)
          report_mismatch("raw_corr", out_if.raw_corr, want.raw);
        if (out_if.norm_corr_q15 !== want.norm)
          report_mismatch("norm_corr_q15", out_if.norm_corr_q15, want.norm);
        if (out_if.status !== want.st)
          report_mismatch("status", out_if.status, want.st);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] sa;
    logic signed [SAMPLE_W-1:0] sb;
    int        vlen;
    int        rand_items;
    int        new_idle;
    vec_kind_t kind;

    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.sample_a  = '0;
    in_if.sample_b  = '0;
    in_if.last_pair = 1'b0;
    out_if.ready    = 1'b0;
    send_idle_pct   = 21;
    recv_stall_pct  = 65;
    rand_items      = 0;
    clear_sums();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i])
      for (int r = 0; r < dir_tab[i].reps; r++)
        send_pair(dir_tab[i].a, dir_tab[i].b, dir_tab[i].last && (r == dir_tab[i].reps - 1),
                  dir_tab[i].typed, dir_tab[i].want);

    // hold the sender until the directed words are all back
    wait_drained();

    while (rand_items < RAND_ITEMS) begin
      new_idle = (rand_items >= 2 * RAND_ITEMS / 3) ? 0 :
                 (rand_items >= RAND_ITEMS / 3) ? 65 : 21;
      if (new_idle != send_idle_pct) begin
        wait_drained();
        send_idle_pct  = new_idle;
        recv_stall_pct = (new_idle == 65) ? 21 : 0;
      end
      // short vectors; the length limit is covered by the table
      vlen = $urandom_range(12, 1);
      kind = vec_kind_t'($urandom_range(VEC_EXTREME));
      for (int i = 0; i < vlen; i++) begin
        sa = SAMPLE_W'($urandom);
        sb = SAMPLE_W'($urandom);
        case (kind)
          VEC_A_ZERO: sa = '0;
          VEC_B_ZERO: sb = '0;
          VEC_SAME:   sb = sa;
          VEC_NEG:    sb = -sa;
          VEC_EXTREME: begin
            case ($urandom_range(4))
              0:       sa = -8'sd128;
              1:       sa = 8'sd127;
              2:       sa = 8'sd0;
              3:       sa = -8'sd1;
              default: sa = 8'sd1;
            endcase
            sb = ($urandom_range(1) == 0) ? -sa : sa;
          end
          default: ;
        endcase
        send_pair(sa, sb, i == vlen - 1, 1'b0, NO_RES);
      end
      rand_items += vlen;
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (err_cnt == 0 && corr_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
